### rtl/icu_pkg.sv
// ----------------------------------------------------------------------------
// icu_pkg: shared types and constants for the interval cut update block
// Command, status and register codes, the sequencer states, and the
// saturating helper used by the shared adder.
// ----------------------------------------------------------------------------
package icu_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Command codes carried on the input tuser
	localparam logic [1:0] CMD_DEEP    = 2'd0;
	localparam logic [1:0] CMD_CENTRAL = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Status codes carried on the output tuser
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOSOLN   = 2'd1;
	localparam logic [1:0] STAT_NOEFFECT = 2'd2;

	// Configuration register indexes
	localparam logic REG_INIT_CENTER = 1'b0;
	localparam logic REG_INIT_RADIUS = 1'b1;

	// Reset values
	localparam logic [31:0] INIT_CENTER_RST = 32'sd0;
	localparam logic [30:0] INIT_RADIUS_RST = 31'd65536;

	localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN32 = 32'h8000_0000;
	localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
	localparam logic [61:0] TAU_SQ_MAX = 62'h3FFF_FFFF_0000_0001;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RG,
		ST_TAU,
		ST_MUL_TT,
		ST_DIV,
		ST_QUOT,
		ST_BOUND,
		ST_EDGE,
		ST_WIDTH,
		ST_HALF,
		ST_CTR,
		ST_DONE
	} state_t;

	// Strobes from the sequencer to the datapath
	typedef struct packed {
		logic take;      // input request accepted this cycle
		logic out_load;  // load the output register
		logic mul_sq;    // multiplier squares tau instead of radius * |g|
	} ctl_t;

	// Clamp a 34-bit signed sum to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic [33:0] v);
		logic [31:0] r;
		begin
			if (!v[33] && (v[32] || v[31])) begin
				r = MAX32;
			end else if (v[33] && !(v[32] && v[31])) begin
				r = MIN32;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

endpackage

### rtl/interval_cut_update_top.sv
// ----------------------------------------------------------------------------
// interval_cut_update_top: one-dimensional ellipsoid cut on a search interval
// Holds a center and radius, records tau squared and applies deep cuts,
// central cuts and restarts using one multiplier, one divider step and one
// saturating adder under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): s_tuser carries the command, s_tdata the gradient and
//   the offset. A request is taken when s_tvalid and s_tready are both high.
//   Output stream (m_*): one result per request; m_tuser carries the status,
//   m_tdata the center, radius and tau squared after the request.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 start
//   center, 1 start radius); write only while the block is idle.
// Sequence (N = 32 + FRAC_BITS divider steps, 48 by default)
//   Deep cut: the multiply and window test, then N divider steps; the
//   divider retires one quotient bit per cycle. A deep cut that ends at the
//   window test (no solution, no effect) skips the divider, as does a
//   central cut. A restart or unused command goes straight to the result.
//   s_tready is high only in the idle state, so a new request is taken at
//   the earliest in the cycle after the previous result is loaded.
// Stall: a finished result waits in the output register; the block takes the
//   next request meanwhile and only holds in its last step if that register
//   is still full.
// Reset: center 0, radius 65536, tau squared 0, start registers at the same
//   values; no result is pending.
// ----------------------------------------------------------------------------
module interval_cut_update_top #(
	parameter int FRAC_BITS = icu_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // [31:0] gradient, [63:32] offset
	input  logic [1:0]   s_tuser,   // [1:0] cmd
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [31:0] center, [62:32] radius,
	                                // [124:63] tau_squared, [127:125] zero
	output logic [1:0]   m_tuser    // [1:0] status
);

	import icu_pkg::*;

	localparam int DIVW = 32 + FRAC_BITS;
	localparam int CNTW = $clog2(DIVW);
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DIVW - 1);

	state_t state_q, state_d;
	ctl_t   ctl;

	// configuration
	logic [31:0] init_center_q;
	logic [30:0] init_radius_q;

	// architectural state
	logic [31:0] center_q;
	logic [30:0] radius_q;
	logic [61:0] tau_sq_q;

	// request
	logic [1:0]  cmd_q;
	logic [31:0] grad_q;
	logic [31:0] offs_q;
	logic [1:0]  status_q;

	// working registers
	logic [63:0]     prod_q;
	logic [30:0]     tau_q;
	logic [DIVW-1:0] dvd_q;
	logic [31:0]     rem_q;
	logic [CNTW-1:0] cnt_q;
	logic [31:0]     quot_q;
	logic [31:0]     bound_q;
	logic [31:0]     edge_q;

	// output register
	logic         out_valid_q;
	logic [1:0]   out_status_q;
	logic [31:0]  out_center_q;
	logic [30:0]  out_radius_q;
	logic [61:0]  out_tau_sq_q;

	// combinational datapath
	logic [31:0] gmag, bmag;
	logic        gpos, gzero;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [62:0] tau_full;
	logic [30:0] tau_sat;
	logic signed [32:0] beta_x, tau_x, ntau_x;
	logic        too_deep, too_shallow;
	logic [32:0] rem_sh;
	logic [33:0] div_diff;
	logic        div_ge;
	logic        quot_neg;
	logic [DIVW-1:0] quot_mag;
	logic        quot_hi;
	logic [31:0] lo_v, up_v;
	logic [33:0] add_a, add_b, add_res;
	logic        add_sub;
	logic [31:0] add_sat;

	// Operand decode
	assign gmag  = grad_q[31] ? (32'd0 - grad_q) : grad_q;
	assign bmag  = offs_q[31] ? (32'd0 - offs_q) : offs_q;
	assign gzero = (grad_q == 32'd0);
	assign gpos  = !grad_q[31] && !gzero;

	// Shared multiplier: radius * |g|, then tau * tau
	assign mul_a = ctl.mul_sq ? {1'b0, tau_q} : {1'b0, radius_q};
	assign mul_b = ctl.mul_sq ? {1'b0, tau_q} : gmag;
	assign mul_p = mul_a * mul_b;

	// Scale the product and clamp tau
	assign tau_full = prod_q[62:0] >> FRAC_BITS;
	assign tau_sat  = (|tau_full[62:31]) ? MAX31 : tau_full[30:0];

	// Deep cut window test against +-tau
	assign beta_x      = {offs_q[31], offs_q};
	assign tau_x       = {2'b00, tau_q};
	assign ntau_x      = 33'sd0 - tau_x;
	assign too_deep    = beta_x > tau_x;
	assign too_shallow = beta_x < ntau_x;

	// Restoring divider step
	assign rem_sh   = {rem_q, dvd_q[DIVW-1]};
	assign div_diff = {1'b0, rem_sh} - {2'b00, gmag};
	assign div_ge   = !div_diff[33];

	// Sign and clamp the quotient
	assign quot_neg = offs_q[31] ^ grad_q[31];
	assign quot_mag = dvd_q;
	assign quot_hi  = quot_neg ?
		((|quot_mag[DIVW-1:32]) || (quot_mag[31] && (|quot_mag[30:0]))) :
		(|quot_mag[DIVW-1:31]);

	// Ends of the clipped interval
	assign up_v = gpos ? bound_q : edge_q;
	assign lo_v = gpos ? edge_q  : bound_q;

	// Shared saturating adder
	always_comb begin
		add_a   = {{2{center_q[31]}}, center_q};
		add_b   = 34'd0;
		add_sub = 1'b0;
		case (state_q)
			ST_BOUND: begin
				add_b   = {{2{quot_q[31]}}, quot_q};
				add_sub = 1'b1;
			end
			ST_EDGE: begin
				add_b   = {3'b000, radius_q};
				add_sub = gpos;
			end
			ST_WIDTH: begin
				add_a   = {{2{up_v[31]}}, up_v};
				add_b   = {{2{lo_v[31]}}, lo_v};
				add_sub = 1'b1;
			end
			ST_CTR: begin
				if (cmd_q == CMD_DEEP) begin
					add_a   = {{2{lo_v[31]}}, lo_v};
					add_b   = {3'b000, radius_q};
					add_sub = 1'b0;
				end else begin
					add_b   = {3'b000, radius_q};
					add_sub = gpos;
				end
			end
			default: begin
				add_b = 34'd0;
			end
		endcase
	end
	assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
	assign add_sat = sat32(add_res);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == CMD_DEEP || s_tuser == CMD_CENTRAL) begin
						state_d = ST_MUL_RG;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL_RG: state_d = ST_TAU;
			ST_TAU:    state_d = ST_MUL_TT;
			ST_MUL_TT: begin
				if (cmd_q == CMD_CENTRAL) begin
					state_d = ST_HALF;
				end else if (too_deep || too_shallow || gzero) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_QUOT;
				end
			end
			ST_QUOT:  state_d = ST_BOUND;
			ST_BOUND: state_d = ST_EDGE;
			ST_EDGE:  state_d = ST_WIDTH;
			ST_WIDTH: state_d = ST_CTR;
			ST_HALF:  state_d = ST_CTR;
			ST_CTR:   state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		ctl.take     = (state_q == ST_IDLE) && s_tvalid;
		ctl.out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);
		ctl.mul_sq   = (state_q == ST_MUL_TT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_center_q <= INIT_CENTER_RST;
			init_radius_q <= INIT_RADIUS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INIT_CENTER: init_center_q <= cfg_data;
				REG_INIT_RADIUS: init_radius_q <= cfg_data[30:0];
				default: init_radius_q <= init_radius_q;
			endcase
		end
	end

	// Interval and tau state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= INIT_CENTER_RST;
			radius_q <= INIT_RADIUS_RST;
			tau_sq_q <= 62'd0;
		end else begin
			if (ctl.take && s_tuser == CMD_RESTART) begin
				center_q <= init_center_q;
				radius_q <= init_radius_q;
			end
			if (state_q == ST_MUL_TT) begin
				tau_sq_q <= mul_p[61:0];
			end
			if (state_q == ST_HALF) begin
				radius_q <= radius_q >> 1;
			end
			// take the clipped width, clamp negative to zero, halve it
			if (state_q == ST_WIDTH) begin
				radius_q <= add_res[33] ? 31'd0 : add_res[31:1];
			end
			if (state_q == ST_CTR) begin
				center_q <= add_sat;
			end
		end
	end

	// Request capture and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= CMD_DEEP;
			status_q <= STAT_OK;
		end else begin
			if (ctl.take) begin
				cmd_q <= s_tuser;
				if (s_tuser == CMD_DEEP || s_tuser == CMD_CENTRAL ||
				    s_tuser == CMD_RESTART) begin
					status_q <= STAT_OK;
				end else begin
					status_q <= STAT_NOEFFECT;
				end
			end
			if (state_q == ST_MUL_TT && cmd_q == CMD_DEEP) begin
				if (too_deep) begin
					status_q <= STAT_NOSOLN;
				end else if (too_shallow || gzero) begin
					status_q <= STAT_NOEFFECT;
				end
			end
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			grad_q <= s_tdata[31:0];
			offs_q <= s_tdata[63:32];
		end
		if (state_q == ST_MUL_RG) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_TAU) begin
			tau_q <= tau_sat;
		end
		// load |offset| scaled by 2^F into the divider
		if (state_q == ST_MUL_TT) begin
			dvd_q <= {bmag, {FRAC_BITS{1'b0}}};
			rem_q <= 32'd0;
			cnt_q <= '0;
		end
		// advance one quotient bit
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? div_diff[31:0] : rem_sh[31:0];
			dvd_q <= {dvd_q[DIVW-2:0], div_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == ST_QUOT) begin
			if (quot_hi) begin
				quot_q <= quot_neg ? MIN32 : MAX32;
			end else if (quot_neg) begin
				quot_q <= 32'd0 - quot_mag[31:0];
			end else begin
				quot_q <= quot_mag[31:0];
			end
		end
		if (state_q == ST_BOUND) begin
			bound_q <= add_sat;
		end
		if (state_q == ST_EDGE) begin
			edge_q <= add_sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= status_q;
			out_center_q <= center_q;
			out_radius_q <= radius_q;
			out_tau_sq_q <= tau_sq_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_tau_sq_q, out_radius_q, out_center_q};

	// Checks
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after taking a request");

	a_restart_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.take && s_tuser == CMD_RESTART) |=>
		(center_q == $past(init_center_q) && radius_q == $past(init_radius_q)))
		else $error("restart did not load the start interval");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CNT_LAST))
		else $error("divider step count out of range");

	a_tau_sq_max: assert property (@(posedge clk) disable iff (!arst_n)
		tau_sq_q <= TAU_SQ_MAX)
		else $error("tau squared exceeds the square of the clamped tau");

endmodule
